### rtl/core/brars_pkg.sv
// brars_pkg: shared types, widths and codes of the block range add / range sum unit
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package brars_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;

    localparam int DEF_ELEMENTS   = 1024;
    localparam int DEF_BLOCK_SIZE = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY     = 2'd0,
        MODE_POINT_ADD = 2'd1,
        MODE_RANGE_ADD = 2'd2
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [INDEX_W-1:0]        index_lo;
        logic [INDEX_W-1:0]        index_hi;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] range_sum;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_A,
        S_DRAIN_A,
        S_WALK_B,
        S_DRAIN_B,
        S_MID,
        S_MID_DRAIN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic idle;        // ready for a new item
        logic clear;       // clearing pass step
        logic elem_issue;  // issue element read at the walk counter
        logic blk_issue;   // issue block read at the walk counter
        logic bsum_wr;     // fold segment total into its block sum
        logic seg_b;       // set up the upper partial block
        logic seg_mid;     // set up the full middle blocks
        logic load_out;    // move the finished sum to the output register
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic op_none;
        logic is_query;
        logic single;
        logic has_mid;
        logic walk_end;
        logic clear_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/brars_req_if.sv
// brars_req_if: valid/ready channel carrying one request item
// depends on brars_pkg for the payload type
`timescale 1ns / 1ps
`default_nettype none

interface brars_req_if;
    import brars_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/brars_rsp_if.sv
// brars_rsp_if: valid/ready channel carrying one range sum item
// depends on brars_pkg for the payload type
`timescale 1ns / 1ps
`default_nettype none

interface brars_rsp_if;
    import brars_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/brars_ctrl.sv
// brars_ctrl: sequencer for clearing, partial block walks and the middle block walk
// depends on brars_pkg for state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module brars_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  brars_pkg::status_t status,
    output brars_pkg::cmd_t    cmd
);
    import brars_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t finish_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        finish_state = status.is_query ? S_RESULT : S_IDLE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (status.accept && !status.op_none)
                begin
                    state_next = S_WALK_A;
                end
            end
            S_WALK_A:
            begin
                cmd.elem_issue = 1'b1;
                if (status.walk_end)
                begin
                    state_next = S_DRAIN_A;
                end
            end
            S_DRAIN_A:
            begin
                cmd.bsum_wr = 1'b1;
                if (status.single)
                begin
                    state_next = finish_state;
                end
                else
                begin
                    cmd.seg_b  = 1'b1;
                    state_next = S_WALK_B;
                end
            end
            S_WALK_B:
            begin
                cmd.elem_issue = 1'b1;
                if (status.walk_end)
                begin
                    state_next = S_DRAIN_B;
                end
            end
            S_DRAIN_B:
            begin
                cmd.bsum_wr = 1'b1;
                if (status.has_mid)
                begin
                    cmd.seg_mid = 1'b1;
                    state_next  = S_MID;
                end
                else
                begin
                    state_next = finish_state;
                end
            end
            S_MID:
            begin
                cmd.blk_issue = 1'b1;
                if (status.walk_end)
                begin
                    state_next = S_MID_DRAIN;
                end
            end
            S_MID_DRAIN:
            begin
                state_next = finish_state;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/brars_dpath.sv
// brars_dpath: element, block sum and pending add memories, walk counter, accumulators
// depends on brars_pkg, brars_req_if and brars_rsp_if; driven by brars_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module brars_dpath #(
    parameter int ELEMENTS   = brars_pkg::DEF_ELEMENTS,
    parameter int BLOCK_SIZE = brars_pkg::DEF_BLOCK_SIZE
) (
    input  logic               clk,
    input  logic               rst_n,
    brars_req_if.sink          query,
    brars_rsp_if.source        result,
    input  brars_pkg::cmd_t    cmd,
    output brars_pkg::status_t status
);
    import brars_pkg::*;

    localparam int IDX_W  = $clog2(ELEMENTS);
    localparam int OFF_W  = $clog2(BLOCK_SIZE);
    localparam int BLOCKS = (ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BLK_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int XW     = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;

    // storage
    logic [SUM_W-1:0] elem_mem [ELEMENTS];
    logic [SUM_W-1:0] bsum_mem [BLOCKS];
    logic [SUM_W-1:0] pend_mem [BLOCKS];

    logic [SUM_W-1:0] elem_rd_reg;
    logic [SUM_W-1:0] bsum_rd_reg;
    logic [SUM_W-1:0] pend_rd_reg;

    // control registers
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             ev_reg, ev_next;
    logic             bv_reg, bv_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [IDX_W-1:0] end_reg, end_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [BLK_W-1:0] bx_reg, bx_next;
    logic [BLK_W-1:0] by_reg, by_next;
    logic [IDX_W-1:0] ea_reg, ea_next;
    logic [BLK_W-1:0] ba_reg, ba_next;
    logic             is_add_reg, is_add_next;
    logic [SUM_W-1:0] val_reg, val_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] seg_reg, seg_next;
    logic [SUM_W-1:0] out_sum_reg, out_sum_next;

    // item decode
    logic             accept;
    logic             point;
    logic             swap;
    logic [IDX_W-1:0] lo_raw, hi_raw, lo_c, hi_c;
    logic [BLK_W-1:0] bx_c, by_c;

    // memory ports
    logic             elem_we, bsum_we, pend_we, clr_blk;
    logic [IDX_W-1:0] elem_wa;
    logic [BLK_W-1:0] bsum_wa, pend_wa, blk_ra;
    logic [SUM_W-1:0] elem_wd, bsum_wd, pend_wd;
    logic [SUM_W-1:0] pend_scaled;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [INDEX_W-1:0] raw);
        logic [XW-1:0] ext;
        ext = XW'(raw);
        if (ext >= XW'(ELEMENTS))
        begin
            clamp_idx = IDX_W'(ELEMENTS - 1);
        end
        else
        begin
            clamp_idx = IDX_W'(ext);
        end
    endfunction

    assign query.ready = cmd.idle;
    assign accept      = query.valid && cmd.idle;

    // a point add is a range add over one element
    always_comb
    begin
        lo_raw = clamp_idx(query.data.index_lo);
        hi_raw = clamp_idx(query.data.index_hi);
        point  = (query.data.mode == MODE_POINT_ADD);
        swap   = !point && (lo_raw > hi_raw);
        lo_c   = swap ? hi_raw : lo_raw;
        hi_c   = point ? lo_raw : (swap ? lo_raw : hi_raw);
        bx_c   = BLK_W'(lo_c >> OFF_W);
        by_c   = BLK_W'(hi_c >> OFF_W);
    end

    always_comb
    begin
        status.accept     = accept;
        status.op_none    = !(query.data.mode == MODE_QUERY
                              || query.data.mode == MODE_POINT_ADD
                              || query.data.mode == MODE_RANGE_ADD);
        status.is_query   = !is_add_reg;
        status.single     = (bx_reg == by_reg);
        status.has_mid    = ((BLK_W+1)'(by_reg) > ((BLK_W+1)'(bx_reg) + (BLK_W+1)'(1)));
        status.walk_end   = (cnt_reg == end_reg);
        status.clear_done = (cnt_reg == IDX_W'(ELEMENTS - 1));
        status.out_free   = !out_valid_reg || result.ready;
    end

    // memory write and read selection
    always_comb
    begin
        clr_blk     = (cnt_reg < IDX_W'(BLOCKS)) || (BLOCKS == ELEMENTS);
        pend_scaled = pend_rd_reg << OFF_W;
        blk_ra      = cmd.blk_issue ? BLK_W'(cnt_reg) : blk_reg;

        elem_we = cmd.clear || (ev_reg && is_add_reg);
        elem_wa = cmd.clear ? cnt_reg : ea_reg;
        elem_wd = cmd.clear ? '0 : (elem_rd_reg + val_reg);

        bsum_we = (cmd.clear && clr_blk) || (cmd.bsum_wr && is_add_reg);
        bsum_wa = cmd.clear ? BLK_W'(cnt_reg) : blk_reg;
        bsum_wd = cmd.clear ? '0 : (bsum_rd_reg + seg_reg);

        pend_we = (cmd.clear && clr_blk) || (bv_reg && is_add_reg);
        pend_wa = cmd.clear ? BLK_W'(cnt_reg) : ba_reg;
        pend_wd = cmd.clear ? '0 : (pend_rd_reg + val_reg);
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_wa] <= elem_wd;
        end
        elem_rd_reg <= elem_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bsum_we)
        begin
            bsum_mem[bsum_wa] <= bsum_wd;
        end
        bsum_rd_reg <= bsum_mem[blk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_wa] <= pend_wd;
        end
        pend_rd_reg <= pend_mem[blk_ra];
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        hi_next        = hi_reg;
        blk_next       = blk_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        is_add_next    = is_add_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        seg_next       = seg_reg;
        ev_next        = cmd.elem_issue;
        bv_next        = cmd.blk_issue;
        ea_next        = cnt_reg;
        ba_next        = BLK_W'(cnt_reg);
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;

        if (accept)
        begin
            cnt_next    = lo_c;
            end_next    = (bx_c == by_c) ? hi_c : IDX_W'({bx_c, {OFF_W{1'b1}}});
            hi_next     = hi_c;
            blk_next    = bx_c;
            bx_next     = bx_c;
            by_next     = by_c;
            is_add_next = (query.data.mode != MODE_QUERY);
            val_next    = {{(SUM_W-VALUE_W){query.data.value[VALUE_W-1]}}, query.data.value};
            acc_next    = '0;
            seg_next    = '0;
        end
        else
        begin
            if ((cmd.clear && !status.clear_done)
                || ((cmd.elem_issue || cmd.blk_issue) && !status.walk_end))
            begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
            // segment total for the block sum, counted at issue
            if (cmd.elem_issue)
            begin
                seg_next = seg_reg + val_reg;
            end
            if (cmd.seg_b)
            begin
                blk_next = by_reg;
                cnt_next = IDX_W'({by_reg, {OFF_W{1'b0}}});
                end_next = hi_reg;
                seg_next = '0;
            end
            if (cmd.seg_mid)
            begin
                cnt_next = IDX_W'(bx_reg) + IDX_W'(1);
                end_next = IDX_W'(by_reg) - IDX_W'(1);
            end
            // partial blocks: element plus its block's pending add
            if (ev_reg && !is_add_reg)
            begin
                acc_next = acc_reg + elem_rd_reg + pend_rd_reg;
            end
            // full blocks: block sum plus block size times pending add
            if (bv_reg && !is_add_reg)
            begin
                acc_next = acc_reg + bsum_rd_reg + pend_scaled;
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_sum_next   = acc_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ev_reg        <= 1'b0;
            bv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ev_reg        <= ev_next;
            bv_reg        <= bv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg     <= end_next;
        hi_reg      <= hi_next;
        blk_reg     <= blk_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        ea_reg      <= ea_next;
        ba_reg      <= ba_next;
        is_add_reg  <= is_add_next;
        val_reg     <= val_next;
        acc_reg     <= acc_next;
        seg_reg     <= seg_next;
        out_sum_reg <= out_sum_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.data.range_sum = out_sum_reg;

    a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ev_reg && bv_reg))
        else $error("element and block stages active together");

    a_bsum_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bsum_wr |-> ev_reg)
        else $error("block sum folded without the last element in flight");

    a_out_settled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!ev_reg && !bv_reg))
        else $error("sum loaded while accumulation still pending");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.elem_issue || cmd.blk_issue) |-> (cnt_reg <= end_reg))
        else $error("walk counter ran past its segment end");

endmodule

`default_nettype wire

### rtl/core/block_range_add_range_sum_unit.sv
// block_range_add_range_sum_unit: top level, controller plus datapath
// depends on brars_pkg, brars_req_if, brars_rsp_if, brars_ctrl and brars_dpath
// sequence: an item walks the elements of its lower partial block, then those of its upper
//   partial block when the ends lie in different blocks, then the full middle blocks lying
//   between them; a range sum then loads the output register, waiting while that register
//   is still held
// throughput: one item at a time, set by the controller, which raises ready only when idle
// reset: asynchronous, then a clearing pass that zeroes the memories with ready held low
`timescale 1ns / 1ps
`default_nettype none

module block_range_add_range_sum_unit #(
    parameter int ELEMENTS   = brars_pkg::DEF_ELEMENTS,
    parameter int BLOCK_SIZE = brars_pkg::DEF_BLOCK_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,
    brars_req_if.sink   query,
    brars_rsp_if.source result
);
    import brars_pkg::*;

    cmd_t    cmd;
    status_t status;

    brars_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    brars_dpath #(
        .ELEMENTS   (ELEMENTS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire
